// ----- hw/rtl/wbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel blocking detector package
// Shared widths, register indexes, beat types and pipeline control struct.
// ----------------------------------------------------------------------------
package wbd_pkg;

    localparam int HISTORY_DEF = 30;

    localparam int DIST_W  = 32;
    localparam int SPD_W   = 16;
    localparam int SCALE_W = 20;
    localparam int ABS_W   = 16;
    localparam int REL_W   = 10;

    localparam int PER_MILLE = 1000;

    // compute stages in each wheel datapath
    localparam int NSTG = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_THR    = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RST   = 20'd10486;
    localparam logic [ABS_W-1:0]   ABS_THR_RST = 16'd320;
    localparam logic [REL_W-1:0]   REL_THR_RST = 10'd950;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance_right;
        logic signed [DIST_W-1:0] distance_left;
        logic signed [SPD_W-1:0]  speed_right;
        logic signed [SPD_W-1:0]  speed_left;
    } t_in_beat;

    typedef struct packed {
        logic right_blocked;
        logic left_blocked;
        logic side_blocked;
        logic fully_blocked;
    } t_out_beat;

    // one history entry, both wheels
    typedef struct packed {
        logic signed [DIST_W-1:0] dist_r;
        logic signed [DIST_W-1:0] dist_l;
        logic signed [SPD_W-1:0]  spd_r;
        logic signed [SPD_W-1:0]  spd_l;
    } t_entry;

    typedef struct packed {
        logic [NSTG-1:0] ld;    // stage load strobes, stage 0 = tick accepted
    } t_pipe_ctl;

endpackage
`default_nettype wire

// ----- hw/rtl/wheel_blocking_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel blocking detector
// Compares odometer travel with commanded speed over a sliding window.
// ----------------------------------------------------------------------------
// Usage:
//  - Tick channel (i_in_valid / o_in_stall / i_in): one beat per motor tick
//    carrying both wheel distances and commanded speeds.
//  - Result channel (o_out_valid / i_out_stall / o_out): exactly one beat per
//    tick, in order, with the right/left/side/fully blocked flags.
//  - Config channel (i_cfg_valid / o_cfg_ready): always ready; index selects
//    tick scale, absolute threshold or relative threshold. Write only while
//    idle. Unknown indexes are dropped.
//  - Throughput: one tick per cycle while not stalled. A row of HISTORY-1
//    history cells shifts on each tick, so the oldest entry is always at the
//    end of the row, and a running sum per wheel tracks the row's speeds.
//  - Pipeline: 5 compute stages, the first loaded on the accepting edge,
//    then the output register that holds the result beat.
//  - Receiver stall: each stage holds while the one after it holds, so
//    bubbles are squeezed out and ticks are still taken until the pipe fills.
//  - Reset: thresholds to defaults, history speeds and sums to zero, fill
//    count to zero; the first HISTORY results are all zero.
// ----------------------------------------------------------------------------
module wheel_blocking_detector #(
    parameter int HISTORY = wbd_pkg::HISTORY_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // tick beats
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire wbd_pkg::t_in_beat                 i_in,
    // result beats
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output wbd_pkg::t_out_beat                     o_out,
    // register writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [wbd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [wbd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wbd_pkg::*;

    localparam int FILL_W = $clog2(HISTORY + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY);

    // ---------------------------------------------------------------- config
    logic [SCALE_W-1:0] r_scale;
    logic [ABS_W-1:0]   r_abs_thr;
    logic [REL_W-1:0]   r_rel_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= SCALE_RST;
            r_abs_thr <= ABS_THR_RST;
            r_rel_thr <= REL_THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TICK_SCALE: r_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_ABS_THR:    r_abs_thr <= i_cfg_data[ABS_W-1:0];
                CFG_REL_THR:    r_rel_thr <= i_cfg_data[REL_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------- pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_rdy;
    logic            w_rdy_out;
    logic            w_ld_out;
    logic            w_accept;
    t_pipe_ctl       w_ctl;

    always_comb begin
        w_rdy_out       = !o_out_valid || !i_out_stall;
        w_rdy[NSTG-1]   = !r_vld[NSTG-1] || w_rdy_out;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_in_stall = !w_rdy[0];
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ld_out   = r_vld[NSTG-1] && w_rdy_out;

    always_comb begin
        w_ctl.ld[0] = w_accept;
        for (int k = 1; k < NSTG; k++) begin
            w_ctl.ld[k] = r_vld[k-1] && w_rdy[k];
        end
        for (int k = 0; k < NSTG - 1; k++) begin
            n_vld[k] = w_ctl.ld[k] || (r_vld[k] && !w_ctl.ld[k+1]);
        end
        n_vld[NSTG-1] = w_ctl.ld[NSTG-1] || (r_vld[NSTG-1] && !w_ld_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // ---------------------------------------------------------- history row
    // w_chain[0] is the incoming tick, w_chain[k] the tick k ticks back.
    t_entry w_chain [HISTORY];

    assign w_chain[0] = '{dist_r: i_in.distance_right, dist_l: i_in.distance_left,
                          spd_r:  i_in.speed_right,    spd_l:  i_in.speed_left};

    for (genvar g = 0; g < HISTORY - 1; g++) begin : g_cell
        wbd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_entry (w_chain[g]),
            .o_entry (w_chain[g+1])
        );
    end

    // ---------------------------------------------------------- wheel tests
    logic w_blk_r;
    logic w_blk_l;

    wbd_wheel #(.HISTORY(HISTORY)) u_wheel_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_dist_new (w_chain[0].dist_r),
        .i_dist_old (w_chain[HISTORY-1].dist_r),
        .i_spd_new  (w_chain[0].spd_r),
        .i_spd_old  (w_chain[HISTORY-1].spd_r),
        .i_scale    (r_scale),
        .i_abs_thr  (r_abs_thr),
        .i_rel_thr  (r_rel_thr),
        .o_blocked  (w_blk_r)
    );

    wbd_wheel #(.HISTORY(HISTORY)) u_wheel_l (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_dist_new (w_chain[0].dist_l),
        .i_dist_old (w_chain[HISTORY-1].dist_l),
        .i_spd_new  (w_chain[0].spd_l),
        .i_spd_old  (w_chain[HISTORY-1].spd_l),
        .i_scale    (r_scale),
        .i_abs_thr  (r_abs_thr),
        .i_rel_thr  (r_rel_thr),
        .o_blocked  (w_blk_l)
    );

    // ------------------------------------------------- fill count and output
    // The fill count only gates results, so it is kept here at the end of
    // the pipe, where ticks leave in order.
    logic [FILL_W-1:0] r_fill;
    logic              w_full;
    t_out_beat         w_res;
    t_out_beat         r_out;
    logic              r_out_valid;

    assign w_full = r_fill >= FILL_FULL;

    always_comb begin
        w_res.right_blocked = w_full && w_blk_r;
        w_res.left_blocked  = w_full && w_blk_l;
        w_res.side_blocked  = w_full && (w_blk_r || w_blk_l);
        w_res.fully_blocked = w_full && w_blk_r && w_blk_l;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_ld_out || (r_out_valid && i_out_stall);
            if (w_ld_out) begin
                if (!w_full) begin
                    r_fill <= r_fill + FILL_W'(1);
                end else if (w_res.fully_blocked) begin
                    r_fill <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ------------------------------------------------------------ assertions
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond history depth");

    a_full_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld_out && w_res.fully_blocked) |=> (r_fill == '0))
        else $error("fill count not restarted after full blocking");

    a_flag_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out.fully_blocked ==
                          (o_out.right_blocked && o_out.left_blocked)) &&
                         (o_out.side_blocked ==
                          (o_out.right_blocked || o_out.left_blocked))))
        else $error("inconsistent blocked flags");

    a_tick_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_vld[0])
        else $error("accepted tick lost at pipe entry");

endmodule
`default_nettype wire

// ----- hw/rtl/wbd_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel blocking detector history cell
// One history entry; takes its neighbour's entry on every accepted tick.
// ----------------------------------------------------------------------------
module wbd_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_shift,
    input  wire wbd_pkg::t_entry i_entry,
    output wbd_pkg::t_entry      o_entry
);
    import wbd_pkg::*;

    logic signed [DIST_W-1:0] r_dist_r;
    logic signed [DIST_W-1:0] r_dist_l;
    logic signed [SPD_W-1:0]  r_spd_r;
    logic signed [SPD_W-1:0]  r_spd_l;

    // distances need no reset: never used before the row has filled
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_dist_r <= i_entry.dist_r;
            r_dist_l <= i_entry.dist_l;
        end
    end

    // speeds start at zero so the running sums stay consistent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spd_r <= '0;
            r_spd_l <= '0;
        end else if (i_shift) begin
            r_spd_r <= i_entry.spd_r;
            r_spd_l <= i_entry.spd_l;
        end
    end

    assign o_entry = '{dist_r: r_dist_r, dist_l: r_dist_l,
                       spd_r:  r_spd_r,  spd_l:  r_spd_l};

endmodule
`default_nettype wire

// ----- hw/rtl/wbd_wheel.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel blocking detector wheel datapath
// Running speed sum and five-stage blocking test for one wheel.
// ----------------------------------------------------------------------------
module wbd_wheel #(
    parameter int HISTORY = wbd_pkg::HISTORY_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire wbd_pkg::t_pipe_ctl                i_ctl,
    input  wire logic signed [wbd_pkg::DIST_W-1:0] i_dist_new,
    input  wire logic signed [wbd_pkg::DIST_W-1:0] i_dist_old,
    input  wire logic signed [wbd_pkg::SPD_W-1:0]  i_spd_new,
    input  wire logic signed [wbd_pkg::SPD_W-1:0]  i_spd_old,
    input  wire logic [wbd_pkg::SCALE_W-1:0]       i_scale,
    input  wire logic [wbd_pkg::ABS_W-1:0]         i_abs_thr,
    input  wire logic [wbd_pkg::REL_W-1:0]         i_rel_thr,
    output logic                                   o_blocked
);
    import wbd_pkg::*;

    localparam int SUM_W  = SPD_W + $clog2(HISTORY);
    localparam int DIFF_W = DIST_W + 1;
    localparam int MEAS_W = DIFF_W + 16;
    localparam int EXP_W  = SUM_W + SCALE_W + 1;
    localparam int ERR_W  = ((EXP_W > MEAS_W) ? EXP_W : MEAS_W) + 1;
    localparam int PROD_W = ERR_W + REL_W;

    logic signed [SUM_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [DIFF_W-1:0] r_diff1;
    logic signed [EXP_W-1:0]  r_expq;
    logic signed [ERR_W-1:0]  r_err;
    logic [ERR_W-1:0]         r_exp_mag;
    logic [ERR_W-1:0]         r_meas_mag;
    logic [ERR_W-1:0]         r_err_mag;
    logic [ERR_W-1:0]         r_big;
    logic                     r_abs_ok;
    logic [PROD_W-1:0]        r_err_k;
    logic [PROD_W-1:0]        r_rel_p;

    logic signed [SUM_W-1:0]  n_acc;
    logic signed [MEAS_W-1:0] w_meas;
    logic [EXP_W-1:0]         w_exp_abs;
    logic [MEAS_W-1:0]        w_meas_abs;
    logic [ERR_W-1:0]         w_err_abs;

    // sum of the speeds held in the history cells
    assign n_acc = r_acc + SUM_W'(i_spd_new) - SUM_W'(i_spd_old);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.ld[0]) begin
            r_acc <= n_acc;
        end
    end

    // s0: measured travel and speed sum snapshot
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_diff <= DIFF_W'(i_dist_new) - DIFF_W'(i_dist_old);
            r_sum  <= r_acc;
        end
    end

    // s1: expected travel, Q16
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[1]) begin
            r_expq  <= EXP_W'(r_sum) * EXP_W'($signed({1'b0, i_scale}));
            r_diff1 <= r_diff;
        end
    end

    // s2: error and magnitudes
    assign w_meas     = {r_diff1, 16'b0};
    assign w_exp_abs  = r_expq[EXP_W-1] ? EXP_W'(-r_expq) : EXP_W'(r_expq);
    assign w_meas_abs = w_meas[MEAS_W-1] ? MEAS_W'(-w_meas) : MEAS_W'(w_meas);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[2]) begin
            r_err      <= ERR_W'(r_expq) - ERR_W'(w_meas);
            r_exp_mag  <= ERR_W'(w_exp_abs);
            r_meas_mag <= ERR_W'(w_meas_abs);
        end
    end

    // s3: |error| and larger travel
    assign w_err_abs = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[3]) begin
            r_err_mag <= w_err_abs;
            r_big     <= (r_meas_mag > r_exp_mag) ? r_meas_mag : r_exp_mag;
        end
    end

    // s4: absolute test and cross-multiplied relative test
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[4]) begin
            r_abs_ok <= r_err_mag > ERR_W'({i_abs_thr, 16'b0});
            r_err_k  <= PROD_W'(r_err_mag) * PROD_W'(PER_MILLE);
            r_rel_p  <= PROD_W'(i_rel_thr) * PROD_W'(r_big);
        end
    end

    assign o_blocked = r_abs_ok && (r_err_k > r_rel_p);

endmodule
`default_nettype wire
